// File: hdl/mme_pkg.sv
// Shared constants and types for the matrix multiply engine.
`default_nettype none

package mme_pkg;

   localparam int DEFAULT_MAX_DIM = 8;
   localparam int ELEM_W          = 32;
   localparam int DIM_W           = 4;
   localparam int POS_W           = 3;
   localparam int CMD_W           = 2;
   localparam int CSR_IDX_W       = 2;
   localparam int PROD_W          = 2 * ELEM_W;
   localparam int FRAC_W          = 16;

   localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_ROWS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLS = 2'd3;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic first;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// File: hdl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: matrix stores, sequencer and result register.
//
// Channel  Direction  Ports                                   Moves
// req      in         req_valid/ready, command, indices, elem one load or compute request
// rsp      out        rsp_valid/ready, value, row, col, flags one element of C or an error
// csr      in         csr_valid/ready, index, data            one dimension register write
//
// A compute request yields a_rows * b_cols results, with dimensions clamped to
// 1..MAX_DIM; a dimension mismatch yields a single error result. Each result waits
// in the emit state while the result channel stalls.
// Each inner term passes three steps: store read, multiply, accumulate in the single MAC.
// Reset clears the sequencer and sets every dimension to one; the stores are not cleared.
// The last result may wait in the output register while the next request is accepted.
`default_nettype none

module matrix_multiply_engine #(
   parameter int MAX_DIM = mme_pkg::DEFAULT_MAX_DIM
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mme_pkg::CMD_W-1:0]        req_command,
   input  logic [mme_pkg::POS_W-1:0]        req_row_index,
   input  logic [mme_pkg::POS_W-1:0]        req_col_index,
   input  logic signed [mme_pkg::ELEM_W-1:0] req_element,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [mme_pkg::ELEM_W-1:0] rsp_product_value,
   output logic [mme_pkg::POS_W-1:0]        rsp_out_row,
   output logic [mme_pkg::POS_W-1:0]        rsp_out_col,
   output logic                             rsp_dim_error,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mme_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mme_pkg::DIM_W-1:0]        csr_data
);
   import mme_pkg::*;

   localparam int Depth = MAX_DIM * MAX_DIM;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_ACC  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
      logic [DIM_W-1:0] e;
      if (r == '0) begin
         e = DIM_W'(1);
      end else if (r > DIM_W'(MAX_DIM)) begin
         e = DIM_W'(MAX_DIM);
      end else begin
         e = r;
      end
      return e;
   endfunction

   state_type           state_ff, state_in;
   logic [IdxW-1:0]     i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                err_ff, err_in;
   logic [DIM_W-1:0]    a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [DIM_W-1:0]    ar_eff, ac_eff, br_eff, bc_eff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]    rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic                rsp_err_ff, rsp_err_in, rsp_last_ff, rsp_last_in;

   logic [ELEM_W-1:0]   mem_a [Depth];
   logic [ELEM_W-1:0]   mem_b [Depth];
   logic [ELEM_W-1:0]   a_rd_ff, b_rd_ff;
   logic [AddrW-1:0]    wr_addr, a_rd_addr, b_rd_addr;
   logic                req_fire, in_range, out_free;
   logic                last_k, last_j, last_i;
   mac_ctrl_type        mac_ctrl;
   logic [ELEM_W-1:0]   mac_result;

   assign ar_eff = eff_dim(a_rows_ff);
   assign ac_eff = eff_dim(a_cols_ff);
   assign br_eff = eff_dim(b_rows_ff);
   assign bc_eff = eff_dim(b_cols_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign in_range  = (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);
   assign wr_addr   = AddrW'(32'(req_row_index) * MAX_DIM + 32'(req_col_index));
   assign a_rd_addr = AddrW'(32'(i_ff) * MAX_DIM + 32'(k_ff));
   assign b_rd_addr = AddrW'(32'(k_ff) * MAX_DIM + 32'(j_ff));

   assign last_k = (DIM_W'(k_ff) == ac_eff - DIM_W'(1));
   assign last_j = (DIM_W'(j_ff) == bc_eff - DIM_W'(1));
   assign last_i = (DIM_W'(i_ff) == ar_eff - DIM_W'(1));

   assign mac_ctrl.mul_en = (state_ff == ST_MUL);
   assign mac_ctrl.acc_en = (state_ff == ST_ACC);
   assign mac_ctrl.first  = (k_ff == '0);

   always_ff @(posedge clock) begin
      if (req_fire && in_range && (req_command == CMD_LOAD_A)) begin
         mem_a[wr_addr] <= req_element;
      end
      if (req_fire && in_range && (req_command == CMD_LOAD_B)) begin
         mem_b[wr_addr] <= req_element;
      end
      if (state_ff == ST_READ) begin
         a_rd_ff <= mem_a[a_rd_addr];
         b_rd_ff <= mem_b[b_rd_addr];
      end
   end

   mme_mac #(
      .MAX_DIM (MAX_DIM)
   ) u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .op_a   (a_rd_ff),
      .op_b   (b_rd_ff),
      .result (mac_result)
   );

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_command == CMD_COMPUTE)) begin
               i_in = '0;
               j_in = '0;
               k_in = '0;
               if (ac_eff != br_eff) begin
                  err_in   = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  err_in   = 1'b0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (last_k) begin
               state_in = ST_EMIT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_value_in = '0;
                  rsp_row_in   = '0;
                  rsp_col_in   = '0;
                  rsp_err_in   = 1'b1;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_value_in = mac_result;
                  rsp_row_in   = POS_W'(i_ff);
                  rsp_col_in   = POS_W'(j_ff);
                  rsp_err_in   = 1'b0;
                  rsp_last_in  = last_i && last_j;
                  k_in         = '0;
                  if (last_i && last_j) begin
                     state_in = ST_IDLE;
                  end else if (last_j) begin
                     j_in     = '0;
                     i_in     = i_ff + 1'b1;
                     state_in = ST_READ;
                  end else begin
                     j_in     = j_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         a_rows_ff    <= DIM_W'(1);
         a_cols_ff    <= DIM_W'(1);
         b_rows_ff    <= DIM_W'(1);
         b_cols_ff    <= DIM_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_A_ROWS: a_rows_ff <= csr_data;
               CSR_A_COLS: a_cols_ff <= csr_data;
               CSR_B_ROWS: b_rows_ff <= csr_data;
               CSR_B_COLS: b_cols_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_dim_error     = rsp_err_ff;
   assign rsp_last          = rsp_last_ff;

   a_err_result_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_last_ff && (rsp_value_ff == '0))
      else $error("Error result is not a lone last result with zero value.");

   a_compute_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_command == CMD_COMPUTE) |=> (state_ff != ST_IDLE))
      else $error("Compute request did not start the sequencer.");

   a_inner_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (DIM_W'(k_ff) < ac_eff))
      else $error("Inner index ran past the inner dimension.");

   a_row_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_err_ff |-> (DIM_W'(rsp_row_ff) < ar_eff)
         && (DIM_W'(rsp_col_ff) < bc_eff))
      else $error("Result position lies outside the product matrix.");

endmodule

`default_nettype wire

// File: hdl/mme_mac.sv
// Shared multiply-accumulate unit with Q16.16 truncation and saturation.
`default_nettype none

module mme_mac #(
   parameter int MAX_DIM = mme_pkg::DEFAULT_MAX_DIM
) (
   input  logic                          clock,
   input  mme_pkg::mac_ctrl_type         ctrl,
   input  logic [mme_pkg::ELEM_W-1:0]    op_a,
   input  logic [mme_pkg::ELEM_W-1:0]    op_b,
   output logic [mme_pkg::ELEM_W-1:0]    result
);
   import mme_pkg::*;

   localparam int SumBits = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 0;
   localparam int AccW    = PROD_W + SumBits + 1;
   localparam int TopW    = AccW - (ELEM_W + FRAC_W) + 1;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [AccW-1:0]   acc_ff;
   logic [TopW-1:0]          top_bits;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= $signed(op_a) * $signed(op_b);
      end
      if (ctrl.acc_en) begin
         acc_ff <= (ctrl.first ? AccW'(0) : acc_ff) + AccW'(prod_ff);
      end
   end

   assign top_bits = acc_ff[AccW-1:ELEM_W+FRAC_W-1];

   always_comb begin
      if ((top_bits == '0) || (top_bits == '1)) begin
         result = acc_ff[ELEM_W+FRAC_W-1:FRAC_W];
      end else if (acc_ff[AccW-1]) begin
         result = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire
